>>> sv/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg
// Shared types, constants and twiddle helpers for the band energy analyzer.
// ----------------------------------------------------------------------------
package fba_pkg;

   localparam int SAMPLE_W = 16;
   localparam int TW_W     = 18;
   localparam int SPEC_W   = 32;
   localparam int LEVEL_W  = 26;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
   localparam longint unsigned PIH_Q30 = 64'd1686629713;

   typedef enum logic [12:0] {
      ST_CLEAR     = 13'b0000000000001,
      ST_IDLE      = 13'b0000000000010,
      ST_MAC       = 13'b0000000000100,
      ST_ROUND     = 13'b0000000001000,
      ST_READ      = 13'b0000000010000,
      ST_SQUARE    = 13'b0000000100000,
      ST_SQRT_GO   = 13'b0000001000000,
      ST_SQRT_WAIT = 13'b0000010000000,
      ST_DIVL_GO   = 13'b0000100000000,
      ST_DIVL_WAIT = 13'b0001000000000,
      ST_DIVH_GO   = 13'b0010000000000,
      ST_DIVH_WAIT = 13'b0100000000000,
      ST_DONE      = 13'b1000000000000
   } state_type;

   // clamp Q30 to [0, 1.0] and round to Q16
   function automatic longint q30_to_q16(longint v);
      longint t;
      t = v;
      if (t < 0) t = 0;
      if (t > (longint'(1) << 30)) t = longint'(1) << 30;
      return (t + 8192) >>> 14;
   endfunction

endpackage

>>> sv/fft_band_energy_analyzer_unit.sv
// Samples are taken while idle; input is held off while a frame is processed.
// A frame of n >= 8 samples runs one multiply accumulate per memory entry and
// a 32-step root for each of its n/4 bins, then two divisions, and posts the
// result; a shorter frame skips the transform and goes straight to posting.
// Reset: a clearing pass zeroes the sample memory first.
// ----------------------------------------------------------------------------
// fft_band_energy_analyzer_unit
// Collects a sample frame, runs a DFT bin by bin, reports mean band levels.
// ----------------------------------------------------------------------------
module fft_band_energy_analyzer_unit
   import fba_pkg::*;
#(
   parameter int FRAME_SIZE = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [LEVEL_W-1:0]         rsp_bass_level,
   output logic [LEVEL_W-1:0]         rsp_treble_level
);

   localparam int IDX_W = $clog2(FRAME_SIZE);
   localparam int CNT_W = $clog2(FRAME_SIZE + 1);
   localparam int PRD_W = SAMPLE_W + TW_W;
   localparam int ACC_W = PRD_W + IDX_W;
   localparam int SUM_W = 32 + IDX_W;
   localparam int EIG_W = CNT_W - 3;
   localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(32768);

   state_type state_ff, state_in;

   logic [SAMPLE_W-1:0]     sample_mem [FRAME_SIZE];
   logic [2*SPEC_W-1:0]     spec_mem   [FRAME_SIZE];

   logic [IDX_W-1:0]        clr_addr_ff, clr_addr_in;
   logic [CNT_W-1:0]        frame_count_ff, frame_count_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic [IDX_W-1:0]        k_ff, k_in;
   logic [IDX_W-1:0]        m_ff, m_in;
   logic [IDX_W-1:0]        j_ff, j_in;
   logic                    issue_done_ff, issue_done_in;
   logic                    p1_ff, p2_ff;
   logic signed [SAMPLE_W-1:0] smp_q_ff;
   logic [2*SPEC_W-1:0]     spec_q_ff;
   logic [2*TW_W-1:0]       tw_q;
   logic signed [PRD_W-1:0] prod_re_ff, prod_im_ff;
   logic signed [ACC_W-1:0] acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic signed [ACC_W-1:0] rnd_re, rnd_im;
   logic [63:0]             sq_re_ff, sq_im_ff;
   logic [SUM_W-1:0]        lo_sum_ff, lo_sum_in, hi_sum_ff, hi_sum_in;
   logic [LEVEL_W-1:0]      lo_res_ff, lo_res_in, hi_res_ff, hi_res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]      rsp_bass_ff, rsp_bass_in, rsp_treble_ff, rsp_treble_in;

   logic                    smp_we;
   logic [IDX_W-1:0]        smp_wa;
   logic [SAMPLE_W-1:0]     smp_wd;
   logic                    spec_we;
   logic [CNT_W-1:0]        cnt_next;
   logic [IDX_W:0]          j_sum;
   logic [LEVEL_W-1:0]      level_sat;
   logic signed [TW_W-1:0]  tw_c, tw_s;
   logic signed [SPEC_W-1:0] rr, ii;

   logic                    sqrt_start, sqrt_done;
   logic                    div_start, div_done;
   logic [31:0]             sqrt_root;
   logic [SUM_W-1:0]        div_dvd, div_quo;

   assign tw_c = signed'(tw_q[2*TW_W-1:TW_W]);
   assign tw_s = signed'(tw_q[TW_W-1:0]);
   assign rr   = signed'(spec_q_ff[SPEC_W-1:0]);
   assign ii   = signed'(spec_q_ff[2*SPEC_W-1:SPEC_W]);

   assign rnd_re = (acc_re_ff + RND_HALF) >>> 16;
   assign rnd_im = (acc_im_ff + RND_HALF) >>> 16;
   assign j_sum  = (IDX_W+1)'(j_ff) + (IDX_W+1)'(k_ff);
   assign level_sat = (div_quo > SUM_W'(LEVEL_MAX)) ? LEVEL_MAX : div_quo[LEVEL_W-1:0];

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      frame_count_in = frame_count_ff;
      n_in           = n_ff;
      k_in           = k_ff;
      m_in           = m_ff;
      j_in           = j_ff;
      issue_done_in  = issue_done_ff;
      acc_re_in      = acc_re_ff;
      acc_im_in      = acc_im_ff;
      lo_sum_in      = lo_sum_ff;
      hi_sum_in      = hi_sum_ff;
      lo_res_in      = lo_res_ff;
      hi_res_in      = hi_res_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_bass_in    = rsp_bass_ff;
      rsp_treble_in  = rsp_treble_ff;
      sqrt_start     = 1'b0;
      div_start      = 1'b0;
      div_dvd        = lo_sum_ff;
      smp_we         = 1'b0;
      smp_wa         = clr_addr_ff;
      smp_wd         = '0;
      spec_we        = 1'b0;
      cnt_next       = frame_count_ff;

      if (p2_ff) begin
         acc_re_in = acc_re_ff + ACC_W'(prod_re_ff);
         acc_im_in = acc_im_ff - ACC_W'(prod_im_ff);
      end

      case (state_ff)
         ST_CLEAR: begin
            smp_we      = 1'b1;
            clr_addr_in = clr_addr_ff + IDX_W'(1);
            if (clr_addr_ff == IDX_W'(FRAME_SIZE - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (frame_count_ff < CNT_W'(FRAME_SIZE)) begin
                  smp_we   = 1'b1;
                  smp_wa   = frame_count_ff[IDX_W-1:0];
                  smp_wd   = req_sample;
                  cnt_next = frame_count_ff + CNT_W'(1);
               end
               frame_count_in = cnt_next;
               if (req_last) begin
                  frame_count_in = '0;
                  n_in           = cnt_next;
                  k_in           = '0;
                  lo_sum_in      = '0;
                  hi_sum_in      = '0;
                  lo_res_in      = '0;
                  hi_res_in      = '0;
                  if (cnt_next[CNT_W-1:3] == EIG_W'(0)) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in      = ST_MAC;
                     m_in          = '0;
                     j_in          = '0;
                     issue_done_in = 1'b0;
                     acc_re_in     = '0;
                     acc_im_in     = '0;
                  end
               end
            end
         end
         ST_MAC: begin
            if (!issue_done_ff) begin
               m_in = m_ff + IDX_W'(1);
               if (j_sum >= (IDX_W+1)'(FRAME_SIZE)) begin
                  j_in = IDX_W'(j_sum - (IDX_W+1)'(FRAME_SIZE));
               end else begin
                  j_in = j_sum[IDX_W-1:0];
               end
               if (m_ff == IDX_W'(FRAME_SIZE - 1)) begin
                  issue_done_in = 1'b1;
               end
            end else if (!p1_ff && !p2_ff) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            spec_we  = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            state_in = ST_SQRT_GO;
         end
         ST_SQRT_GO: begin
            sqrt_start = 1'b1;
            state_in   = ST_SQRT_WAIT;
         end
         ST_SQRT_WAIT: begin
            if (sqrt_done) begin
               if (CNT_W'(k_ff) < (n_ff >> 3)) begin
                  lo_sum_in = lo_sum_ff + SUM_W'(sqrt_root);
               end else begin
                  hi_sum_in = hi_sum_ff + SUM_W'(sqrt_root);
               end
               k_in = k_ff + IDX_W'(1);
               if (CNT_W'(k_ff) + CNT_W'(1) == (n_ff >> 2)) begin
                  state_in = ST_DIVL_GO;
               end else begin
                  state_in      = ST_MAC;
                  m_in          = '0;
                  j_in          = '0;
                  issue_done_in = 1'b0;
                  acc_re_in     = '0;
                  acc_im_in     = '0;
               end
            end
         end
         ST_DIVL_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIVL_WAIT;
         end
         ST_DIVL_WAIT: begin
            if (div_done) begin
               lo_res_in = level_sat;
               state_in  = ST_DIVH_GO;
            end
         end
         ST_DIVH_GO: begin
            div_start = 1'b1;
            div_dvd   = hi_sum_ff;
            state_in  = ST_DIVH_WAIT;
         end
         ST_DIVH_WAIT: begin
            if (div_done) begin
               hi_res_in = level_sat;
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_bass_in   = lo_res_ff;
               rsp_treble_in = hi_res_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (smp_we) begin
         sample_mem[smp_wa] <= smp_wd;
      end
      smp_q_ff <= signed'(sample_mem[m_ff]);
   end

   always_ff @(posedge clock) begin
      if (spec_we) begin
         spec_mem[k_ff] <= {rnd_im[SPEC_W-1:0], rnd_re[SPEC_W-1:0]};
      end
      spec_q_ff <= spec_mem[k_ff];
   end

   fba_twiddle_rom #(
      .FRAME_SIZE (FRAME_SIZE)
   ) u_rom (
      .clock (clock),
      .addr  (j_ff),
      .tw_q  (tw_q)
   );

   fba_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .operand (sq_re_ff + sq_im_ff),
      .done    (sqrt_done),
      .root    (sqrt_root)
   );

   fba_divider #(
      .DVD_W (SUM_W),
      .DVS_W (EIG_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (n_ff[CNT_W-1:3]),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         frame_count_ff <= '0;
         issue_done_ff  <= 1'b1;
         p1_ff          <= 1'b0;
         p2_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         frame_count_ff <= frame_count_in;
         issue_done_ff  <= issue_done_in;
         p1_ff          <= (state_ff == ST_MAC) && !issue_done_ff;
         p2_ff          <= p1_ff;
         rsp_valid_ff   <= rsp_valid_in;
      end
      n_ff          <= n_in;
      k_ff          <= k_in;
      m_ff          <= m_in;
      j_ff          <= j_in;
      prod_re_ff    <= smp_q_ff * tw_c;
      prod_im_ff    <= smp_q_ff * tw_s;
      acc_re_ff     <= acc_re_in;
      acc_im_ff     <= acc_im_in;
      sq_re_ff      <= rr * rr;
      sq_im_ff      <= ii * ii;
      lo_sum_ff     <= lo_sum_in;
      hi_sum_ff     <= hi_sum_in;
      lo_res_ff     <= lo_res_in;
      hi_res_ff     <= hi_res_in;
      rsp_bass_ff   <= rsp_bass_in;
      rsp_treble_ff <= rsp_treble_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bass_level   = rsp_bass_ff;
   assign rsp_treble_level = rsp_treble_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      frame_count_ff <= CNT_W'(FRAME_SIZE))
      else $error("frame count beyond frame size");

   a_sqrt_done_state: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> (state_ff == ST_SQRT_WAIT))
      else $error("root finished outside its wait state");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVL_WAIT || state_ff == ST_DIVH_WAIT))
      else $error("division finished outside its wait state");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result raised outside done state");
`endif

endmodule

>>> sv/fba_twiddle_rom.sv
// ----------------------------------------------------------------------------
// fba_twiddle_rom
// Twiddle table {cos, sin} in Q16, built at elaboration, registered read.
// ----------------------------------------------------------------------------
module fba_twiddle_rom
   import fba_pkg::*;
#(
   parameter int FRAME_SIZE = 1024
) (
   input  logic                          clock,
   input  logic [$clog2(FRAME_SIZE)-1:0] addr,
   output logic [2*TW_W-1:0]             tw_q
);

   typedef logic [2*TW_W-1:0] rom_type [FRAME_SIZE];

   // factorial factor pairs of the cosine and sine series terms
   localparam longint unsigned TC_DIV [10] = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380};
   localparam longint unsigned TS_DIV [10] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};

   function automatic rom_type build_rom();
      rom_type        t;
      longint unsigned q, r, x, tc, ts;
      longint         sc, ss, c, s, cq, sq;
      for (int j = 0; j < FRAME_SIZE; j++) begin
         q = 0;
         r = 64'(4 * j);
         while (r >= 64'(FRAME_SIZE)) begin
            r = r - 64'(FRAME_SIZE);
            q = q + 1;
         end
         x    = (PIH_Q30 * r) / FRAME_SIZE;
         tc   = longint'(1) << 30;
         ts   = x;
         sc   = longint'(tc);
         ss   = longint'(ts);
         for (int n = 1; n <= 10; n++) begin
            tc = (tc * x) >> 30;
            tc = (tc * x) >> 30;
            tc = tc / TC_DIV[n-1];
            ts = (ts * x) >> 30;
            ts = (ts * x) >> 30;
            ts = ts / TS_DIV[n-1];
            if (n[0]) begin
               sc = sc - longint'(tc);
               ss = ss - longint'(ts);
            end else begin
               sc = sc + longint'(tc);
               ss = ss + longint'(ts);
            end
         end
         c = q30_to_q16(sc);
         s = q30_to_q16(ss);
         case (q[1:0])
            2'd0:    begin cq = c;  sq = s;  end
            2'd1:    begin cq = -s; sq = c;  end
            2'd2:    begin cq = -c; sq = -s; end
            default: begin cq = s;  sq = -c; end
         endcase
         t[j] = {TW_W'(cq), TW_W'(sq)};
      end
      return t;
   endfunction

   localparam rom_type TW_ROM = build_rom();

   always_ff @(posedge clock) begin
      tw_q <= TW_ROM[addr];
   end

endmodule

>>> sv/fba_isqrt.sv
// ----------------------------------------------------------------------------
// fba_isqrt
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module fba_isqrt
   import fba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] operand,
   output logic        done,
   output logic [31:0] root
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] v_ff, v_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic [64:0] diff;

   assign diff = {1'b0, v_ff} - ({1'b0, res_ff} + {1'b0, bit_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      v_in    = v_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         v_in    = operand;
         res_in  = '0;
         bit_in  = 64'(1) << 62;
      end else if (busy_ff) begin
         if (!diff[64]) begin
            v_in   = diff[63:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == 64'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      v_ff   <= v_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

>>> sv/fba_divider.sv
// ----------------------------------------------------------------------------
// fba_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fba_divider #(
   parameter int DVD_W = 42,
   parameter int DVS_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CW = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W:0]   sh, diff;

   assign sh   = {rem_ff, quo_ff[DVD_W-1]};
   assign diff = sh - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (!diff[DVS_W]) begin
            rem_in = diff[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = sh[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the frame band energy analyzer.
// Sends sample frames of many lengths under random stalls on both channels.
// A local DFT predictor computes the bass and treble levels of each frame,
// and every result transfer is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module tb
   import fba_pkg::*;
;

   localparam int FRAME = 1024;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct {
      logic [LEVEL_W-1:0] bass;
      logic [LEVEL_W-1:0] treble;
   } band_levels_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic                       req_last;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [LEVEL_W-1:0]         rsp_bass_level;
   logic [LEVEL_W-1:0]         rsp_treble_level;

   int                 cos_q16 [FRAME];
   int                 sin_q16 [FRAME];
   logic signed [15:0] frame_mem [FRAME];
   int                 fill_count;
   band_levels_type    level_queue [$];
   int                 mismatches;
   int                 samples_sent;
   int                 frames_sent;
   int                 tiny_frames;
   int                 results_seen;
   bit                 quiet;
   longint             cycles;

   fft_band_energy_analyzer_unit #(.FRAME_SIZE(FRAME)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_sample(req_sample), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_bass_level(rsp_bass_level), .rsp_treble_level(rsp_treble_level)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 22);
   end

   function automatic int clamp_q16(longint v);
      if (v < 0) v = 0;
      if (v > (longint'(1) << 30)) v = longint'(1) << 30;
      return int'((v + 8192) >>> 14);
   endfunction

   function automatic void build_twiddle_table();
      longint unsigned four, quad, rem, x, tc, ts;
      longint          sc, ss;
      int              c, s;
      for (int j = 0; j < FRAME; j++) begin
         four = 4 * j;
         quad = four / FRAME;
         rem = four - quad * FRAME;
         x = (PIH_Q30 * rem) / FRAME;
         tc = 64'd1 << 30;
         ts = x;
         sc = longint'(tc);
         ss = longint'(ts);
         for (int n = 1; n <= 10; n++) begin
            tc = (tc * x) >> 30;
            tc = (tc * x) >> 30;
            tc = tc / ((2 * n - 1) * (2 * n));
            ts = (ts * x) >> 30;
            ts = (ts * x) >> 30;
            ts = ts / ((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               sc -= longint'(tc);
               ss -= longint'(ts);
            end else begin
               sc += longint'(tc);
               ss += longint'(ts);
            end
         end
         c = clamp_q16(sc);
         s = clamp_q16(ss);
         case (quad % 4)
            0: begin cos_q16[j] = c;  sin_q16[j] = s;  end
            1: begin cos_q16[j] = -s; sin_q16[j] = c;  end
            2: begin cos_q16[j] = -c; sin_q16[j] = -s; end
            default: begin cos_q16[j] = s; sin_q16[j] = -c; end
         endcase
      end
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic longint unsigned bin_energy(int k);
      longint        re, im;
      longint        rr, ii;
      int            j;
      logic [31:0]   re32, im32;
      re = 0;
      im = 0;
      j = 0;
      for (int m = 0; m < FRAME; m++) begin
         re += longint'(frame_mem[m]) * cos_q16[j];
         im -= longint'(frame_mem[m]) * sin_q16[j];
         j += k;
         if (j >= FRAME) j -= FRAME;
      end
      re32 = 32'((re + 32768) >>> 16);
      im32 = 32'((im + 32768) >>> 16);
      rr = longint'(signed'(re32));
      ii = longint'(signed'(im32));
      return floor_sqrt(longint'(unsigned'(rr * rr + ii * ii)));
   endfunction

   function automatic void predict_sample(logic signed [15:0] smp, logic lst);
      int              n, eighth;
      longint unsigned low, high, mag;
      band_levels_type lv;
      if (fill_count < FRAME) begin
         frame_mem[fill_count] = smp;
         fill_count++;
      end
      if (!lst) return;
      n = fill_count;
      fill_count = 0;
      eighth = n / 8;
      low = 0;
      high = 0;
      if (eighth == 0) begin
         tiny_frames++;
      end else begin
         for (int k = 0; k < n / 4; k++) begin
            mag = bin_energy(k);
            if (k < eighth) low += mag;
            else high += mag;
         end
         low /= eighth;
         high /= eighth;
      end
      lv.bass = (low > LEVEL_MAX) ? LEVEL_MAX : LEVEL_W'(low);
      lv.treble = (high > LEVEL_MAX) ? LEVEL_MAX : LEVEL_W'(high);
      level_queue.push_back(lv);
      frames_sent++;
   endfunction

   always @(posedge clock) begin
      band_levels_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (level_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result bass=%0d treble=%0d",
                        rsp_bass_level, rsp_treble_level);
         end else begin
            want = level_queue.pop_front();
            if (want.bass !== rsp_bass_level || want.treble !== rsp_treble_level) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected bass=%0d treble=%0d, got bass=%0d treble=%0d",
                           results_seen, want.bass, want.treble,
                           rsp_bass_level, rsp_treble_level);
            end
         end
      end
   end

   task automatic send_sample(logic signed [15:0] smp, logic lst);
      while (!quiet && $urandom_range(0, 99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= smp;
      req_last <= lst;
      do @(posedge clock); while (!req_ready);
      predict_sample(smp, lst);
      samples_sent++;
   endtask

   function automatic logic signed [15:0] random_sample();
      case ($urandom_range(0, 9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_frame(int len);
      for (int i = 0; i < len; i++)
         send_sample(random_sample(), i == len - 1);
   endtask

   task automatic wait_for_levels();
      req_valid <= 1'b0;
      do @(posedge clock); while (level_queue.size() != 0);
   endtask

   task automatic test_extremes();
      for (int i = 0; i < 8; i++) send_sample(16'sh7fff, i == 7);
      for (int i = 0; i < 8; i++) send_sample(16'sh8000, i == 7);
      send_sample(16'sh0001, 1'b1);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7fff, 1'b1);
      for (int i = 0; i < 6; i++)
         send_sample((i % 2) ? 16'sh8000 : 16'sh7fff, i == 5);
   endtask

   task automatic test_overlong_frame();
      for (int i = 0; i < FRAME + 6; i++)
         send_sample(random_sample(), i == FRAME + 5);
      wait_for_levels();
   endtask

   task automatic test_random_frames(int target);
      int len, pick;
      quiet = 1'b1;
      while (samples_sent < target) begin
         if (samples_sent > 200) quiet = 1'b0;
         pick = $urandom_range(0, 99);
         if (pick < 80) len = $urandom_range(1, 24);
         else if (pick < 95) len = $urandom_range(25, 64);
         else len = $urandom_range(65, 200);
         send_frame(len);
         if ($urandom_range(0, 19) == 0) wait_for_levels();
      end
      quiet = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = '0;
      req_last = 1'b0;
      rsp_ready = 1'b0;
      quiet = 1'b0;
      cycles = 0;
      mismatches = 0;
      samples_sent = 0;
      frames_sent = 0;
      tiny_frames = 0;
      results_seen = 0;
      fill_count = 0;
      foreach (frame_mem[i]) frame_mem[i] = '0;
      build_twiddle_table();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_extremes();
      wait_for_levels();
      test_random_frames(samples_sent + 700);
      test_overlong_frame();
      wait_for_levels();
      repeat (500) @(posedge clock);
      $display("covered %0d samples in %0d frames (%0d below eight samples, one overlong)",
               samples_sent, frames_sent, tiny_frames);
      $display("compared %0d band level results, %0d bad", results_seen, mismatches);
      if (mismatches == 0 && level_queue.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

>>> sim.f
sv/fba_pkg.sv
sv/fba_twiddle_rom.sv
sv/fba_isqrt.sv
sv/fba_divider.sv
sv/fft_band_energy_analyzer_unit.sv
tb/sv/tb.sv
